// ===== src/smcd_pkg.sv =====
// smcd_pkg: types, character codes and matcher step function for the
// script main-call detector; used by the lexer, matcher and top-level files
`default_nettype none

package smcd_pkg;

  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0b;
  localparam logic [7:0] CH_FF    = 8'h0c;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_BSL   = 8'h5c;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_M     = 8'h6d;
  localparam logic [7:0] CH_N     = 8'h6e;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_LINE   = 2'd1,
    MODE_BLOCK  = 2'd2,
    MODE_STRING = 2'd3
  } lex_mode_t;

  typedef enum logic [2:0] {
    PH_WS     = 3'd0,
    PH_M      = 3'd1,
    PH_MA     = 3'd2,
    PH_MAI    = 3'd3,
    PH_MAIN   = 3'd4,
    PH_REJECT = 3'd5
  } match_phase_t;

  typedef struct packed {
    lex_mode_t mode;
    logic      slash_held;
    logic      star_held;
    logic      escape_held;
  } lex_state_t;

  // up to two cleaned characters per raw byte, first one in ch0
  typedef struct packed {
    logic       v0;
    logic [7:0] ch0;
    logic       v1;
    logic [7:0] ch1;
  } clean_chars_t;

  typedef struct packed {
    match_phase_t phase;
    logic         hit;
  } match_res_t;

  function automatic logic is_ws(input logic [7:0] ch);
    return (ch == CH_SP) || (ch == CH_TAB) || (ch == CH_NL) ||
           (ch == CH_VT) || (ch == CH_FF) || (ch == CH_CR);
  endfunction

  function automatic match_res_t match_step(input match_phase_t ph, input logic [7:0] ch);
    match_res_t r;
    r.phase = ph;
    r.hit   = 1'b0;
    if (ch == CH_NL) begin
      r.phase = PH_WS;
    end else begin
      unique case (ph)
        PH_WS: begin
          if (!is_ws(ch)) r.phase = (ch == CH_M) ? PH_M : PH_REJECT;
        end
        PH_M:   r.phase = (ch == CH_A) ? PH_MA : PH_REJECT;
        PH_MA:  r.phase = (ch == CH_I) ? PH_MAI : PH_REJECT;
        PH_MAI: r.phase = (ch == CH_N) ? PH_MAIN : PH_REJECT;
        PH_MAIN: begin
          if (ch == CH_LPAR) begin
            r.hit   = 1'b1;
            r.phase = PH_REJECT;
          end else if (!is_ws(ch)) begin
            r.phase = PH_REJECT;
          end
        end
        default: r.phase = PH_REJECT;
      endcase
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/smcd_if.sv =====
// smcd_in_if and smcd_out_if: valid/ready channels of the detector
// depends on nothing
`default_nettype none

interface smcd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface smcd_out_if;
  logic valid;
  logic ready;
  logic found;
  logic final_res;

  modport source (output valid, output found, output final_res, input ready);
  modport sink   (input valid, input found, input final_res, output ready);
endinterface

`default_nettype wire

// ===== src/smcd_lexer.sv =====
// smcd_lexer: comment and string stripper, next lexer state and cleaned chars
// depends on smcd_pkg
`default_nettype none

module smcd_lexer (
  input  wire smcd_pkg::lex_state_t   cur,
  input  wire logic [7:0]             ch,
  input  wire logic                   last,
  output smcd_pkg::lex_state_t        nxt,
  output smcd_pkg::clean_chars_t      cc
);

  always_comb begin
    nxt    = cur;
    cc.v0  = 1'b0;
    cc.ch0 = ch;
    cc.v1  = 1'b0;
    cc.ch1 = ch;
    unique case (cur.mode)
      smcd_pkg::MODE_LINE: begin
        if (ch == smcd_pkg::CH_NL) begin
          nxt.mode = smcd_pkg::MODE_NORMAL;
          cc.v0    = 1'b1;
        end
      end
      smcd_pkg::MODE_BLOCK: begin
        if (cur.star_held && ch == smcd_pkg::CH_SLASH) begin
          nxt.mode      = smcd_pkg::MODE_NORMAL;
          nxt.star_held = 1'b0;
        end else begin
          nxt.star_held = (ch == smcd_pkg::CH_STAR);
        end
      end
      smcd_pkg::MODE_STRING: begin
        if (cur.escape_held) begin
          nxt.escape_held = 1'b0;
        end else if (ch == smcd_pkg::CH_BSL) begin
          nxt.escape_held = 1'b1;
        end else if (ch == smcd_pkg::CH_QUOTE) begin
          nxt.mode = smcd_pkg::MODE_NORMAL;
        end
      end
      default: begin
        if (cur.slash_held) begin
          nxt.slash_held = 1'b0;
          if (ch == smcd_pkg::CH_SLASH) begin
            nxt.mode = smcd_pkg::MODE_LINE;
          end else if (ch == smcd_pkg::CH_STAR) begin
            nxt.mode      = smcd_pkg::MODE_BLOCK;
            nxt.star_held = 1'b0;
          end else begin
            cc.v0  = 1'b1;
            cc.ch0 = smcd_pkg::CH_SLASH;
            if (ch == smcd_pkg::CH_QUOTE) begin
              nxt.mode        = smcd_pkg::MODE_STRING;
              nxt.escape_held = 1'b0;
            end else begin
              cc.v1 = 1'b1;
            end
          end
        end else if (ch == smcd_pkg::CH_SLASH) begin
          if (last) cc.v0 = 1'b1;
          else nxt.slash_held = 1'b1;
        end else if (ch == smcd_pkg::CH_QUOTE) begin
          nxt.mode        = smcd_pkg::MODE_STRING;
          nxt.escape_held = 1'b0;
        end else begin
          cc.v0 = 1'b1;
        end
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/smcd_matcher.sv =====
// smcd_matcher: line matcher for leading "main(" over up to two cleaned chars
// depends on smcd_pkg
`default_nettype none

module smcd_matcher (
  input  wire smcd_pkg::match_phase_t  phase,
  input  wire logic                    found,
  input  wire smcd_pkg::clean_chars_t  cc,
  output smcd_pkg::match_phase_t       phase_nxt,
  output logic                         found_nxt
);

  smcd_pkg::match_res_t r0;
  smcd_pkg::match_res_t r1;
  smcd_pkg::match_phase_t ph_mid;

  always_comb begin
    r0        = smcd_pkg::match_step(phase, cc.ch0);
    ph_mid    = cc.v0 ? r0.phase : phase;
    r1        = smcd_pkg::match_step(ph_mid, cc.ch1);
    phase_nxt = cc.v1 ? r1.phase : ph_mid;
    found_nxt = found | (cc.v0 & r0.hit) | (cc.v1 & r1.hit);
  end

endmodule

`default_nettype wire

// ===== src/script_main_call_detector_unit.sv =====
// script_main_call_detector_unit: top level of the main-call detector
// depends on smcd_pkg, smcd_if, smcd_lexer and smcd_matcher
//
// Raw script bytes arrive on in_ch, one word per byte with end_of_text set
// on the last byte of a script. Each byte yields exactly one word on out_ch:
// found tells whether a line starting (after optional whitespace) with
// main, optional whitespace and '(' has been seen outside comments and
// strings so far; final_res copies end_of_text.
// An accepted byte sits in an input register; when the result register is
// free or being read, the lexer and line matcher update the scan state and
// load the result register, which drives out_ch.valid. One byte per cycle is
// sustained while out_ch.ready stays high, set by the state update loop.
// When out_ch.ready is low the result register holds its word and the input
// register keeps one more byte, after which in_ch.ready drops.
// Synchronous reset (rst_n low) empties both registers and returns the
// scan state to normal code at line start with found cleared. After the
// result for an end_of_text byte the scan state returns to that same point.
`default_nettype none

module script_main_call_detector_unit (
  input  wire logic          clk,
  input  wire logic          rst_n,
  smcd_in_if.sink            in_ch,
  smcd_out_if.source         out_ch
);

  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;
  logic       out_valid_r;
  logic       out_found_r;
  logic       out_final_r;

  smcd_pkg::lex_state_t   lex_r;
  smcd_pkg::lex_state_t   lex_nxt;
  smcd_pkg::match_phase_t phase_r;
  smcd_pkg::match_phase_t phase_nxt;
  logic                   found_r;
  logic                   found_nxt;
  smcd_pkg::clean_chars_t cc;
  logic                   advance;

  assign advance      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || advance;
  assign out_ch.valid = out_valid_r;
  assign out_ch.found = out_found_r;
  assign out_ch.final_res = out_final_r;

  smcd_lexer u_lexer (
    .cur  (lex_r),
    .ch   (s1_byte_r),
    .last (s1_last_r),
    .nxt  (lex_nxt),
    .cc   (cc)
  );

  smcd_matcher u_matcher (
    .phase     (phase_r),
    .found     (found_r),
    .cc        (cc),
    .phase_nxt (phase_nxt),
    .found_nxt (found_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_byte_r <= in_ch.text_byte;
      s1_last_r <= in_ch.end_of_text;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_found_r <= found_nxt;
      out_final_r <= s1_last_r;
    end
  end

  // scan state, back to start after the last byte
  always_ff @(posedge clk) begin
    if (!rst_n || (advance && s1_last_r)) begin
      lex_r.mode        <= smcd_pkg::MODE_NORMAL;
      lex_r.slash_held  <= 1'b0;
      lex_r.star_held   <= 1'b0;
      lex_r.escape_held <= 1'b0;
      phase_r           <= smcd_pkg::PH_WS;
      found_r           <= 1'b0;
    end else if (advance) begin
      lex_r   <= lex_nxt;
      phase_r <= phase_nxt;
      found_r <= found_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_restart_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    advance && s1_last_r |=> lex_r.mode == smcd_pkg::MODE_NORMAL && !found_r &&
      phase_r == smcd_pkg::PH_WS && !lex_r.slash_held)
    else $error("scan state not cleared after last byte");

  a_found_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    found_r && !(advance && s1_last_r) |=> found_r)
    else $error("found flag dropped inside a script");

  a_result_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_final_r |-> out_found_r == found_r)
    else $error("result word disagrees with found flag");

  a_slash_only_in_code: assert property (@(posedge clk) disable iff (!rst_n)
    lex_r.slash_held |-> lex_r.mode == smcd_pkg::MODE_NORMAL)
    else $error("held slash outside normal code");

  a_flags_match_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (!lex_r.star_held || lex_r.mode == smcd_pkg::MODE_BLOCK) &&
    (!lex_r.escape_held || lex_r.mode == smcd_pkg::MODE_STRING))
    else $error("star or escape flag outside its mode");
`endif

endmodule

`default_nettype wire
